// ===== design/assert_macros.svh =====
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`define BPP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BPP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BPP_ASSERT_NEVER(lbl, cond, msg)
`define BPP_ASSERT_IMP(lbl, ante, cons, msg)
`define BPP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/bpp_pkg.sv =====
package bpp_pkg;
	localparam int COORD_BITS_DEF = 10;
	localparam int CTRL_PTS = 4;
	localparam int FRAC_BITS = 8;
	localparam int T_W = 16;
	localparam int T_FRAC = 15;
	localparam logic [T_W-1:0] T_ONE = 16'h8000;
	localparam int T_HALF = 16384;
	localparam int HALF_PIX = 128;
	localparam int QDEPTH = 8;
	localparam int QA_W = 3;
	localparam int QC_W = 4;
	localparam int FL_W = 3;
	// Offsets from a pixel corner never exceed one and a half pixels.
	localparam int AD_W = 9;
	localparam int SQ_W = 18;
	localparam int D_W = 19;
	localparam int N_W = 35;
	localparam int M_W = 20;
	localparam int ROOT_W = 10;
	localparam int REM_W = 13;
	localparam int R_W = 10;
	localparam logic [15:0] AA_SCALE = 16'd65025;
	localparam logic [7:0] WMAX = 8'd255;

	typedef enum logic [2:0] {
		REG_POINT_A   = 3'd0,
		REG_POINT_B   = 3'd1,
		REG_POINT_C   = 3'd2,
		REG_POINT_D   = 3'd3,
		REG_PLOT_MODE = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic            not_empty;
		logic [QC_W-1:0] count;
	} q_stat_t;
endpackage

// ===== design/cubic_bezier_pixel_plotter.sv =====
// A t passes the front-end stages, the queue, the back-end issue register, the weight
// and root stages and the output register. Throughput: one t per cycle while busy is
// low; antialiasing gives four pixels per t, paced by the back end's single issue port.
// Reset: arst_n clears the control points, the mode, the queue and every valid bit.
// The receiver cannot stall; the strobe carries each pixel beat for one cycle.
`include "assert_macros.svh"
module cubic_bezier_pixel_plotter import bpp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [T_W-1:0]              t_value,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [2*COORD_BITS-1:0]     cfg_data,
	output logic                        strobe,
	output logic signed [COORD_BITS:0]  pixel_x,
	output logic signed [COORD_BITS:0]  pixel_y,
	output logic                        channel,
	output logic [7:0]                  weight,
	output logic                        last
);
	localparam int P_W = COORD_BITS + FRAC_BITS;

	// Configuration registers. Writes are always taken; an unknown index is dropped.
	logic [CTRL_PTS-1:0][2*COORD_BITS-1:0] pts_q;
	logic [1:0] mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= '0;
			mode_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POINT_A: pts_q[0] <= cfg_data;
				REG_POINT_B: pts_q[1] <= cfg_data;
				REG_POINT_C: pts_q[2] <= cfg_data;
				REG_POINT_D: pts_q[3] <= cfg_data;
				REG_PLOT_MODE: mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// The front end never stalls once it has taken a t, so a new beat is only
	// taken while the queue has a free slot for it beyond every point still being evaluated.
	logic take, push, pop;
	logic [2*P_W-1:0] push_data, head;
	logic [FL_W-1:0] inflight;
	q_stat_t q_stat;
	logic [QC_W:0] committed;

	assign committed = (QC_W+1)'(q_stat.count) + (QC_W+1)'(inflight);
	assign busy = (committed >= (QC_W+1)'(QDEPTH));
	assign take = start && !busy;

	bpp_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.t_value   (t_value),
		.pts       (pts_q),
		.push      (push),
		.push_data (push_data),
		.inflight  (inflight)
	);

	bpp_queue #(.DATA_W(2*P_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// With a point held, the back end issues one pixel per cycle into a fixed-length weight pipeline.
	bpp_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.q_stat  (q_stat),
		.q_data  (head),
		.pop     (pop),
		.strobe  (strobe),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.channel (channel),
		.weight  (weight),
		.last    (last)
	);

	`BPP_ASSERT_NEVER(a_no_overflow, push && !pop && (q_stat.count == QC_W'(QDEPTH)), "queue overflow")
	`BPP_ASSERT_NEVER(a_credit, committed > (QC_W+1)'(QDEPTH), "credit count exceeded")
	`BPP_ASSERT_NXT(a_group, strobe && !last, strobe, "antialias group broken up")
	`BPP_ASSERT_IMP(a_red, strobe && !channel, last && (weight == WMAX), "red pixel malformed")
endmodule

// ===== design/bpp_front.sv =====
module bpp_front import bpp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      take,
	input  logic [T_W-1:0]                            t_value,
	input  logic [CTRL_PTS-1:0][2*COORD_BITS-1:0]     pts,
	output logic                                      push,
	output logic [2*(COORD_BITS+FRAC_BITS)-1:0]       push_data,
	output logic [FL_W-1:0]                           inflight
);
	localparam int P_W = COORD_BITS + FRAC_BITS;
	localparam int PR_W = P_W + T_W + 2;

	// Rounded interpolation written as a + (b - a) * t, one multiplier per lane.
	function automatic logic [P_W-1:0] lerp(input logic [P_W-1:0] a,
			input logic [P_W-1:0] b, input logic [T_W-1:0] t);
		logic signed [P_W:0] diff;
		logic signed [PR_W-1:0] prod;
		logic signed [PR_W-1:0] sum;
		logic signed [PR_W-1:0] shr;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		prod = diff * $signed({1'b0, t});
		sum = prod + $signed(PR_W'(T_HALF));
		shr = sum >>> T_FRAC;
		return a + shr[P_W-1:0];
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic [T_W-1:0] t_s1, t_s2, t_s3;
	logic [1:0][2:0][P_W-1:0] l1_s2;
	logic [1:0][1:0][P_W-1:0] l2_s3;
	logic [1:0][P_W-1:0] l3_s4;
	logic [1:0][CTRL_PTS-1:0][P_W-1:0] ctl;

	always_comb begin
		for (int ax = 0; ax < 2; ax++) begin
			for (int i = 0; i < CTRL_PTS; i++) begin
				ctl[ax][i] = {pts[i][ax*COORD_BITS +: COORD_BITS], {FRAC_BITS{1'b0}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= (t_value > T_ONE) ? T_ONE : t_value;
		t_s2 <= t_s1;
		t_s3 <= t_s2;
		for (int ax = 0; ax < 2; ax++) begin
			for (int i = 0; i < 3; i++) begin
				l1_s2[ax][i] <= lerp(ctl[ax][i], ctl[ax][i+1], t_s1);
			end
			for (int i = 0; i < 2; i++) begin
				l2_s3[ax][i] <= lerp(l1_s2[ax][i], l1_s2[ax][i+1], t_s2);
			end
			l3_s4[ax] <= lerp(l2_s3[ax][0], l2_s3[ax][1], t_s3);
		end
	end

	assign push = v_s4;
	assign push_data = {l3_s4[1], l3_s4[0]};
	assign inflight = FL_W'(v_s1) + FL_W'(v_s2) + FL_W'(v_s3) + FL_W'(v_s4);
endmodule

// ===== design/bpp_queue.sv =====
module bpp_queue import bpp_pkg::*; #(
	parameter int DATA_W = 36
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] head,
	output q_stat_t           stat
);
	logic [DATA_W-1:0] mem_q [QDEPTH];
	logic [QA_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QC_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.not_empty = (count_q != '0);
endmodule

// ===== design/bpp_back.sv =====
module bpp_back import bpp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          mode,
	input  q_stat_t                             q_stat,
	input  logic [2*(COORD_BITS+FRAC_BITS)-1:0] q_data,
	output logic                                pop,
	output logic                                strobe,
	output logic signed [COORD_BITS:0]          pixel_x,
	output logic signed [COORD_BITS:0]          pixel_y,
	output logic                                channel,
	output logic [7:0]                          weight,
	output logic                                last
);
	localparam int P_W = COORD_BITS + FRAC_BITS;
	localparam int X_W = COORD_BITS + 1;
	localparam int DF_W = COORD_BITS + 10;
	localparam int PAY_W = 2 * X_W + 3;

	logic hold_q;
	logic [1:0] idx_q;
	logic [1:0][P_W-1:0] pos_q;
	logic aa, last_issue;

	assign aa = mode[1];
	assign last_issue = hold_q && (!aa || idx_q == 2'd3);
	assign pop = q_stat.not_empty && (!hold_q || last_issue);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			hold_q <= 1'b1;
			idx_q <= '0;
		end else if (last_issue) begin
			hold_q <= 1'b0;
		end else if (hold_q) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pos_q <= q_data;
		end
	end

	// Pixel choice and offset from the exact curve point, per axis.
	logic [1:0][X_W-1:0] q_pix;
	logic [1:0][AD_W-1:0] q_abs;

	always_comb begin
		logic [P_W:0] rnd;
		logic signed [X_W-1:0] base;
		logic signed [DF_W-1:0] diff;
		rnd = '0;
		base = '0;
		diff = '0;
		for (int ax = 0; ax < 2; ax++) begin
			rnd = {1'b0, pos_q[ax]} + (P_W+1)'(HALF_PIX);
			if (aa) begin
				base = $signed(rnd[P_W:FRAC_BITS]) - $signed(X_W'(idx_q[ax]));
			end else begin
				base = $signed({1'b0, pos_q[ax][P_W-1:FRAC_BITS]});
			end
			q_pix[ax] = base;
			diff = $signed({base, {FRAC_BITS{1'b0}}}) - $signed({2'b00, pos_q[ax]});
			q_abs[ax] = diff[DF_W-1] ? AD_W'(-diff) : diff[AD_W-1:0];
		end
	end

	logic v_s1, v_s2, v_s3, v_s4;
	logic [PAY_W-1:0] pay_s1, pay_s2, pay_s3, pay_s4;
	logic [1:0][AD_W-1:0] abs_s1;
	logic [1:0][SQ_W-1:0] sq_s2;
	logic [D_W-1:0] d_s3;
	logic [M_W-1:0] m_s4;
	logic [N_W-1:0] n_prod;

	assign n_prod = N_W'(d_s3) * N_W'(AA_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= hold_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pay_s1 <= {q_pix[0], q_pix[1], (aa | mode[0]), (!aa || idx_q == 2'd3), !aa};
		abs_s1 <= q_abs;
		pay_s2 <= pay_s1;
		for (int ax = 0; ax < 2; ax++) begin
			sq_s2[ax] <= SQ_W'(abs_s1[ax]) * SQ_W'(abs_s1[ax]);
		end
		pay_s3 <= pay_s2;
		d_s3 <= D_W'(sq_s2[0]) + D_W'(sq_s2[1]);
		pay_s4 <= pay_s3;
		m_s4 <= n_prod[N_W-1:T_FRAC];
	end

	// Integer square root, one result bit per stage.
	logic sq_v_q [ROOT_W];
	logic [PAY_W-1:0] sq_pay_q [ROOT_W];
	logic [REM_W-1:0] sq_rem_q [ROOT_W];
	logic [ROOT_W-1:0] sq_root_q [ROOT_W];
	logic [M_W-1:0] sq_m_q [ROOT_W];
	logic [REM_W-1:0] rem_d [ROOT_W];
	logic [ROOT_W-1:0] root_d [ROOT_W];

	always_comb begin
		logic [REM_W-1:0] rin;
		logic [ROOT_W-1:0] oin;
		logic [M_W-1:0] min_v;
		logic [REM_W-1:0] rsh;
		logic [REM_W-1:0] trial;
		for (int j = 0; j < ROOT_W; j++) begin
			rin = (j == 0) ? '0 : sq_rem_q[(j == 0) ? 0 : j-1];
			oin = (j == 0) ? '0 : sq_root_q[(j == 0) ? 0 : j-1];
			min_v = (j == 0) ? m_s4 : sq_m_q[(j == 0) ? 0 : j-1];
			rsh = {rin[REM_W-3:0], min_v[M_W-1 -: 2]};
			trial = {1'b0, oin, 2'b01};
			if (rsh >= trial) begin
				rem_d[j] = rsh - trial;
				root_d[j] = {oin[ROOT_W-2:0], 1'b1};
			end else begin
				rem_d[j] = rsh;
				root_d[j] = {oin[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < ROOT_W; j++) begin
				sq_v_q[j] <= 1'b0;
			end
		end else begin
			sq_v_q[0] <= v_s4;
			for (int j = 1; j < ROOT_W; j++) begin
				sq_v_q[j] <= sq_v_q[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_pay_q[0] <= pay_s4;
		sq_m_q[0] <= m_s4 << 2;
		for (int j = 1; j < ROOT_W; j++) begin
			sq_pay_q[j] <= sq_pay_q[j-1];
			sq_m_q[j] <= sq_m_q[j-1] << 2;
		end
		for (int j = 0; j < ROOT_W; j++) begin
			sq_rem_q[j] <= rem_d[j];
			sq_root_q[j] <= root_d[j];
		end
	end

	// Nearest integer radius is half the root rounded up; weight falls off from full.
	logic [R_W-1:0] rad;
	logic [7:0] w_d;
	logic [PAY_W-1:0] pay_f;
	logic strobe_q, channel_q, last_q;
	logic [X_W-1:0] px_q, py_q;
	logic [7:0] weight_q;

	assign pay_f = sq_pay_q[ROOT_W-1];
	assign rad = R_W'(({1'b0, sq_root_q[ROOT_W-1]} + 1'b1) >> 1);

	always_comb begin
		if (pay_f[0]) begin
			w_d = WMAX;
		end else if (rad >= R_W'(WMAX)) begin
			w_d = '0;
		end else begin
			w_d = WMAX - rad[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= sq_v_q[ROOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		px_q <= pay_f[PAY_W-1 -: X_W];
		py_q <= pay_f[X_W+2 -: X_W];
		channel_q <= pay_f[2];
		last_q <= pay_f[1];
		weight_q <= w_d;
	end

	assign strobe = strobe_q;
	assign pixel_x = $signed(px_q);
	assign pixel_y = $signed(py_q);
	assign channel = channel_q;
	assign last = last_q;
	assign weight = weight_q;
endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	import bpp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = COORD_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;

	// One pixel beat as the block is expected to emit it.
	typedef struct packed {
		logic signed [CB:0] px;
		logic signed [CB:0] py;
		logic               ch;
		logic [7:0]         w;
		logic               lst;
	} pixel_beat_t;

	// Scoreboard: holds its own copy of the control points and the mode, works out
	// the pixel beats for each accepted t, and compares emitted beats with them.
	class pixel_scoreboard;
		logic [2*CB-1:0] pts[4];
		logic [1:0]      mode;
		pixel_beat_t     pending[$];
		int              errors;

		function new();
			foreach (pts[i]) pts[i] = '0;
			mode = '0;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [2*CB-1:0] data);
			case (idx)
				REG_POINT_A:   pts[0] = data;
				REG_POINT_B:   pts[1] = data;
				REG_POINT_C:   pts[2] = data;
				REG_POINT_D:   pts[3] = data;
				REG_PLOT_MODE: mode = data[1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned blend(longint unsigned a, longint unsigned b,
				longint unsigned t);
			return (a * (32768 - t) + b * t + 16384) >> 15;
		endfunction

		function longint unsigned curve_axis(int sh, longint unsigned t);
			longint unsigned lv[4];
			for (int i = 0; i < 4; i++)
				lv[i] = longint'((pts[i] >> sh) & ((1 << CB) - 1)) << 8;
			for (int n = 3; n > 0; n--)
				for (int i = 0; i < n; i++)
					lv[i] = blend(lv[i], lv[i+1], t);
			return lv[0];
		endfunction

		// Weight falls off with distance from the exact point; r is the rounded
		// scaled distance, found without a square root.
		function logic [7:0] aa_weight(longint dx, longint dy);
			longint unsigned n, o;
			int r;
			n = 65025 * (dx * dx + dy * dy);
			r = 0;
			for (int k = 1; k <= 256; k++) begin
				o = 2 * k - 1;
				if (o * o * 32768 <= n) r = k;
				else break;
			end
			return (r >= 255) ? 8'd0 : 8'(255 - r);
		endfunction

		function void note_t(logic [15:0] tin);
			longint unsigned t, px, py;
			longint x0, y0, qx, qy;
			pixel_beat_t b;
			t = (tin > 16'h8000) ? 32768 : tin;
			px = curve_axis(0, t);
			py = curve_axis(CB, t);
			if (mode[1] == 1'b0) begin
				b.px = (CB+1)'(px >> 8);
				b.py = (CB+1)'(py >> 8);
				b.ch = mode[0];
				b.w = 8'd255;
				b.lst = 1'b1;
				pending.push_back(b);
			end else begin
				x0 = (px + 128) >> 8;
				y0 = (py + 128) >> 8;
				for (int i = 0; i < 4; i++) begin
					qx = x0 - ((i == 1 || i == 3) ? 1 : 0);
					qy = y0 - ((i >= 2) ? 1 : 0);
					b.px = (CB+1)'(qx);
					b.py = (CB+1)'(qy);
					b.ch = 1'b1;
					b.w = aa_weight(qx * 256 - longint'(px), qy * 256 - longint'(py));
					b.lst = (i == 3);
					pending.push_back(b);
				end
			end
		endfunction

		function void check_beat(pixel_beat_t got);
			pixel_beat_t e;
			if (pending.size() == 0) begin
				$error("pixel beat with nothing expected: x=%0d y=%0d", got.px, got.py);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.px !== e.px) begin
				$error("pixel_x expected %0d actual %0d", e.px, got.px); errors++;
			end
			if (got.py !== e.py) begin
				$error("pixel_y expected %0d actual %0d", e.py, got.py); errors++;
			end
			if (got.ch !== e.ch) begin
				$error("channel expected %0d actual %0d", e.ch, got.ch); errors++;
			end
			if (got.w !== e.w) begin
				$error("weight expected %0d actual %0d", e.w, got.w); errors++;
			end
			if (got.lst !== e.lst) begin
				$error("last expected %0d actual %0d", e.lst, got.lst); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [T_W-1:0] t_value = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [2*CB-1:0] cfg_data = '0;
	logic strobe;
	logic signed [CB:0] pixel_x, pixel_y;
	logic channel, last;
	logic [7:0] weight;

	pixel_scoreboard sb = new();
	int idle_pct = 0;
	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cubic_bezier_pixel_plotter dut (.*);

	// The receiver cannot stall, so every strobe is a beat to check. The watchdog
	// counts cycles in which neither a t, a register write nor a pixel beat moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				sb.check_beat({pixel_x, pixel_y, channel, weight, last});
			if (strobe || (start && !busy) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Offers one t and holds it until the block takes the beat. The idle gap comes
	// first so that start stays high across back-to-back beats.
	task automatic send_t(logic [15:0] tv);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		t_value <= tv;
		do @(posedge clk); while (busy);
		sb.note_t(tv);
	endtask

	// Waits for every expected beat, then for the pipeline to empty, before any
	// register changes underneath it.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [2*CB-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic set_curve(logic [2*CB-1:0] a, b, c, d, logic [1:0] m);
		write_reg(REG_POINT_A, a);
		write_reg(REG_POINT_B, b);
		write_reg(REG_POINT_C, c);
		write_reg(REG_POINT_D, d);
		write_reg(REG_PLOT_MODE, {18'b0, m});
		@(posedge clk);
	endtask

	// Mostly legal t values with a good share of the ends and of values above one.
	function automatic logic [15:0] random_t();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'h8000;
			2: return 16'($urandom_range(16'hFFFF, 16'h8001));
			default: return 16'($urandom_range(32768));
		endcase
	endfunction

	initial begin
		int phases[4] = '{0, 72, 0, 24};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the ends of t, values above one, every mode including the
		// unused one, and points on the grid edge so that neighbours fall at -1.
		set_curve('0, '0, '0, '0, 2'd0);
		send_t(16'h0000);
		send_t(16'hFFFF);
		settle();
		set_curve(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 2'd1);
		send_t(16'h0000);
		send_t(16'h8000);
		send_t(16'h4000);
		settle();
		set_curve(20'h00000, 20'hFFFFF, 20'h003FF, 20'hFFC00, 2'd2);
		foreach (phases[i]) send_t(16'(i * 8192));
		send_t(16'h8001);
		send_t(16'h7FFF);
		send_t(16'h0001);
		settle();
		set_curve(20'h00000, 20'h00000, 20'h00000, 20'h00000, 2'd3);
		send_t(16'h1234);
		send_t(16'h8000);
		settle();
		// An unknown register index must leave everything as it is.
		cfg_valid <= 1'b1;
		cfg_index <= 3'd7;
		cfg_data <= 20'hABCDE;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		send_t(16'h2000);
		settle();

		// Random part: fresh points and mode in each block, idling varied by phase.
		for (int blk = 0; blk < 20; blk++) begin
			idle_pct = phases[blk % 4];
			set_curve(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
				2'($urandom_range(3)));
			for (int n = 0; n < 25; n++) send_t(random_t());
			settle();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
